@@ sv/msf_pkg.sv @@
// Package for the multi-stack shared free list: item types, status codes and
// the command and status structs between controller and datapath. No dependencies.
package msf_pkg;

  // Action codes of a request item.
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // Value returned by a pop from an empty or missing stack.
  localparam logic [31:0] EMPTY_VALUE = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  typedef struct packed {
    logic               action;
    logic [1:0]         stack_sel;
    logic signed [31:0] push_value;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] pop_value;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    lookup;
    logic    fetch;
    logic    push_commit;
    logic    pop_commit;
    logic    emit;
    status_t emit_status;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_pop;
    logic sel_ok;
    logic head_null;
    logic free_null;
    logic rsp_free;
  } ctl_stat_t;

endpackage

@@ sv/msf_datapath.sv @@
// Datapath of the multi-stack shared free list: slot data and link memories,
// stack head memory, free head, fill count and the result register. Uses msf_pkg.
module msf_datapath #(
  parameter int NUM_STACKS      = 4,
  parameter int SLOTS_PER_STACK = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  msf_pkg::req_t      req,
  input  msf_pkg::ctl_cmd_t  cmd,
  output msf_pkg::ctl_stat_t stat,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output msf_pkg::rsp_t      rsp
);
  import msf_pkg::*;

  localparam int POOL  = NUM_STACKS * SLOTS_PER_STACK;
  localparam int LINKW = $clog2(POOL + 1);
  localparam int AW    = (POOL > 1) ? $clog2(POOL) : 1;
  localparam int SW    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam logic [LINKW-1:0] NULL_LINK = LINKW'(POOL);

  // Captured item.
  req_t item;

  // Free list head and count of slots whose link word has been written.
  // Slots at or above the fill count read as their reset link, slot + 1.
  logic [LINKW-1:0] free_head;
  logic [LINKW-1:0] fill;

  // Stack heads with valid bits; an invalid head reads as null.
  logic [LINKW-1:0] head_mem [NUM_STACKS];
  logic [NUM_STACKS-1:0] head_valid;
  logic [LINKW-1:0] head_rd;
  logic             head_vld_rd;

  // Slot link and data memories with registered reads.
  logic [LINKW-1:0] link_mem [POOL];
  logic [31:0]      data_mem [POOL];
  logic [LINKW-1:0] link_raw;
  logic [LINKW-1:0] link_emul;
  logic             link_known;
  logic [31:0]      data_rd;

  logic [SW-1:0]    req_idx;
  logic [SW-1:0]    item_idx;
  logic [LINKW-1:0] head_eff;
  logic [LINKW-1:0] link_eff;
  logic [LINKW-1:0] link_addr;
  logic [LINKW-1:0] link_wr_addr;
  logic [LINKW-1:0] link_wr_data;
  logic             link_we;

  assign req_idx  = SW'(req.stack_sel);
  assign item_idx = SW'(item.stack_sel);
  assign head_eff = head_vld_rd ? head_rd : NULL_LINK;
  assign link_eff = link_known ? link_raw : link_emul;

  // A lookup reads the link of the free head, a fetch that of the stack top.
  assign link_addr = cmd.fetch ? head_eff : free_head;

  // A push links the free slot above the top; a pop returns the top to the free list.
  assign link_we      = cmd.push_commit | cmd.pop_commit;
  assign link_wr_addr = cmd.push_commit ? free_head : head_eff;
  assign link_wr_data = cmd.push_commit ? head_eff : free_head;

  // Status to the controller.
  assign stat.is_pop    = (item.action == ACT_POP);
  assign stat.sel_ok    = (32'(item.stack_sel) < NUM_STACKS);
  assign stat.head_null = (head_eff == NULL_LINK);
  assign stat.free_null = (free_head == NULL_LINK);
  assign stat.rsp_free  = !rsp_valid || rsp_ready;

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= req;
    end
  end

  // Stack head memory: read on lookup, write on commit.
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      head_rd <= head_mem[req_idx];
    end
    if (link_we) begin
      head_mem[item_idx] <= cmd.push_commit ? free_head : link_eff;
    end
  end

  // Head valid bits, free head and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid  <= '0;
      head_vld_rd <= 1'b0;
      free_head   <= '0;
      fill        <= '0;
    end else begin
      if (cmd.lookup) begin
        head_vld_rd <= head_valid[req_idx];
      end
      if (link_we) begin
        head_valid[item_idx] <= 1'b1;
      end
      if (cmd.push_commit) begin
        free_head <= link_eff;
        if (free_head == fill) begin
          fill <= fill + LINKW'(1);
        end
      end else if (cmd.pop_commit) begin
        free_head <= head_eff;
      end
    end
  end

  // Link memory with the fill-count substitute for never-written entries.
  always_ff @(posedge clk) begin
    if (cmd.lookup || cmd.fetch) begin
      link_raw   <= link_mem[link_addr[AW-1:0]];
      link_known <= (link_addr < fill);
      link_emul  <= link_addr + LINKW'(1);
    end
    if (link_we) begin
      link_mem[link_wr_addr[AW-1:0]] <= link_wr_data;
    end
  end

  // Data memory: read the top on fetch, write the pushed value on commit.
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      data_rd <= data_mem[head_eff[AW-1:0]];
    end
    if (cmd.push_commit) begin
      data_mem[free_head[AW-1:0]] <= item.push_value;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.status <= cmd.emit_status;
      if (cmd.pop_commit) begin
        rsp.pop_value <= data_rd;
      end else if (cmd.emit_status == ST_EMPTY) begin
        rsp.pop_value <= EMPTY_VALUE;
      end else begin
        rsp.pop_value <= '0;
      end
    end
  end

  // The free head is either a rewritten slot or the next never-used slot.
  a_free_in_fill: assert property (@(posedge clk) disable iff (rst)
    !stat.free_null |-> free_head <= fill)
    else $error("free head beyond fill count");

  // An exhausted free list means every slot has been used once.
  a_full_fill: assert property (@(posedge clk) disable iff (rst)
    stat.free_null |-> fill == NULL_LINK)
    else $error("free list empty before pool filled");

  // A pop only commits on an existing, non-empty stack.
  a_pop_target: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_commit |-> (stat.sel_ok && !stat.head_null))
    else $error("pop commit on empty stack");

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.rsp_free)
    else $error("result overwritten");

endmodule

@@ sv/msf_ctrl.sv @@
// Controller of the multi-stack shared free list: sequences lookup, fetch and
// commit of one item at a time. Uses msf_pkg.
module msf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  msf_pkg::ctl_stat_t stat,
  output msf_pkg::ctl_cmd_t  cmd
);
  import msf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_FETCH
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  // Command decode and next state.
  always_comb begin
    cmd         = '0;
    cmd.emit_status = ST_OK;
    state_next  = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          cmd.lookup  = 1'b1;
          state_next  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (stat.is_pop) begin
          if (!stat.sel_ok || stat.head_null) begin
            if (stat.rsp_free) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = ST_EMPTY;
              state_next      = S_IDLE;
            end
          end else begin
            cmd.fetch  = 1'b1;
            state_next = S_FETCH;
          end
        end else if (stat.rsp_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
          if (!stat.sel_ok || stat.free_null) begin
            cmd.emit_status = ST_OVERFLOW;
          end else begin
            cmd.push_commit = 1'b1;
          end
        end
      end
      S_FETCH: begin
        if (stat.rsp_free) begin
          cmd.pop_commit = 1'b1;
          cmd.emit       = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sv/multi_stack_shared_free_list.sv @@
// The item is captured and its stack head read on acceptance; from the lookup state a push
// or empty pop registers its result, while a pop of a value first passes the fetch state,
// where the top slot's link and data are read. The next item is accepted the cycle after
// its result is registered, and a result not yet taken holds the item at commit.
// Reset (rst, synchronous) empties all stacks and chains every slot on the free list at
// once: a fill count stands in for the link memory's reset values, so no clearing pass.
module multi_stack_shared_free_list #(
  parameter int NUM_STACKS      = 4,
  parameter int SLOTS_PER_STACK = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  msf_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output msf_pkg::rsp_t rsp
);
  import msf_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // Sequencer.
  msf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Memories, heads and result register.
  msf_datapath #(
    .NUM_STACKS      (NUM_STACKS),
    .SLOTS_PER_STACK (SLOTS_PER_STACK)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
